FILE: src/biq_pkg.sv
// Shared constants, types and register codes for the biquad filter unit.
`default_nettype none

package biq_pkg;

  // Default widths of the datapath
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 32;
  localparam int COEF_FRAC_DEF    = 28;

  // Sample bits consumed by a multiply unit in one cycle with step set
  localparam int DIGIT_W = 4;

  // Coefficient register file
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_A0 = 3'd0,
    COEF_A1 = 3'd1,
    COEF_A2 = 3'd2,
    COEF_B1 = 3'd3,
    COEF_B2 = 3'd4
  } coef_idx_e;

  // Control word from the sequencer to each digit-serial multiply unit
  typedef struct packed {
    logic load;   // capture a new operand, clear the product
    logic step;   // consume one digit
    logic first;  // current digit is the most significant (signed) one
  } mac_ctrl_t;

endpackage : biq_pkg

`default_nettype wire

FILE: src/biq_digit_mac.sv
// Digit-serial multiplier: signed operand shifted out MSB digit first.
`default_nettype none

module biq_digit_mac
  import biq_pkg::*;
#(
  parameter int OP_W   = 16,
  parameter int COEF_W = 32
) (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  mac_ctrl_t                 ctrl_i,
  input  wire  logic signed [OP_W-1:0]    operand_i,
  input  wire  logic signed [COEF_W-1:0]  coef_i,
  output logic signed [OP_W+COEF_W-1:0]   product_o
);

  localparam int ACC_W  = OP_W + COEF_W;
  localparam int TERM_W = COEF_W + DIGIT_W + 1;

  logic [OP_W-1:0]          shreg_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [DIGIT_W-1:0]       digit;
  logic signed [DIGIT_W:0]  digit_val;
  logic signed [TERM_W-1:0] term;

  // Top digit carries the sign, the rest are plain magnitudes
  assign digit     = shreg_q[OP_W-1 -: DIGIT_W];
  assign digit_val = ctrl_i.first ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
  assign term      = TERM_W'(coef_i * digit_val);

  // Horner accumulation: acc = acc * radix + coef * digit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shreg_q <= '0;
      acc_q   <= '0;
    end else if (ctrl_i.load) begin
      shreg_q <= operand_i;
      acc_q   <= '0;
    end else if (ctrl_i.step) begin
      shreg_q <= shreg_q << DIGIT_W;
      acc_q   <= (acc_q <<< DIGIT_W) + ACC_W'(term);
    end
  end

  assign product_o = acc_q;

endmodule : biq_digit_mac

`default_nettype wire

FILE: src/biquad_iir_filter_unit.sv
// Biquad IIR filter, transposed direct form II, with digit-serial multipliers.
//
// Use: samples enter on the s_axis channel (tdata = signed sample) and one
// filtered word leaves on m_axis per sample (tdata = rounded, saturated
// sample; tuser = clip flag). Coefficients a0, a1, a2, b1, b2 (signed, with
// COEF_FRAC fraction bits) are written on the cfg channel, index 0 to 4;
// any such write clears both delay states, other indexes are ignored.
// A new sample is taken only in the idle state, so each one is finished first.
// Each product is built from NDIG = ceil(SAMPLE_WIDTH/4) digits in one of
// three digit-serial units: three feed-forward products run together, then
// units 0 and 1 form the two feedback products on the output sample. The
// states run S_MUL_X, S_ROUND, S_MUL_Y, S_UPDATE, then m_axis_tvalid rises.
// Reset: coefficients return to bypass (a0 = 1.0, others 0), delays clear,
// no output is pending. A stalled receiver holds the result in the output
// register; the next sample is computed meanwhile and waits at its final
// step until the output register frees, so no word is lost.
`default_nettype none

module biquad_iir_filter_unit
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
  parameter int COEF_FRAC    = COEF_FRAC_DEF
) (
  input  wire  logic                               clk_i,
  input  wire  logic                               rst_ni,
  // Input stream
  input  wire  logic                               s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: [SAMPLE_WIDTH-1:0] sample_in, zero padding above
  input  wire  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  // Output stream
  output logic                                     m_axis_tvalid,
  input  wire  logic                               m_axis_tready,
  // tdata: [SAMPLE_WIDTH-1:0] sample_out, zero padding above
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // tuser: [0] clipped
  output logic                                     m_axis_tuser,
  // Coefficient write channel
  input  wire  logic                               cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire  logic [CFG_IDX_W-1:0]               cfg_index_i,
  input  wire  logic [COEF_WIDTH-1:0]              cfg_data_i
);

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int NDIG    = (SAMPLE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int EXT_W   = NDIG * DIGIT_W;
  localparam int PROD_W  = EXT_W + COEF_WIDTH;
  localparam int DELAY_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int SUM_W   = DELAY_W + 2;
  localparam int CNT_W   = (NDIG > 1) ? $clog2(NDIG) : 1;

  localparam logic [COEF_WIDTH-1:0] A0_RESET = COEF_WIDTH'(1) << COEF_FRAC;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [SUM_W-1:0] SMAX = (SUM_W'(1) <<< (SAMPLE_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SMIN = ~SMAX;
  localparam logic signed [SUM_W-1:0] DMAX = (SUM_W'(1) <<< (DELAY_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] DMIN = ~DMAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_X,
    S_ROUND,
    S_MUL_Y,
    S_UPDATE
  } state_e;

  // Clamp a wide sum to the delay width
  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [SUM_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if (v > DMAX) begin
      r = DMAX[DELAY_W-1:0];
    end else if (v < DMIN) begin
      r = DMIN[DELAY_W-1:0];
    end else begin
      r = v[DELAY_W-1:0];
    end
    return r;
  endfunction

  state_e                           state_q;
  logic [CNT_W-1:0]                 cnt_q;
  logic                             out_valid_q;
  logic signed [COEF_WIDTH-1:0]     coef_a0_q, coef_a1_q, coef_a2_q, coef_b1_q, coef_b2_q;
  logic signed [DELAY_W-1:0]        s1_q, s2_q;
  logic signed [SAMPLE_WIDTH-1:0]   y_q;
  logic                             clip_q;
  logic signed [SUM_W-1:0]          t1_q;
  logic [SAMPLE_WIDTH-1:0]          out_sample_q;
  logic                             out_clip_q;

  logic                             in_acc, cfg_acc, cfg_hit, upd_go, last_dig;
  logic signed [EXT_W-1:0]          x_ext, y_ext, op01;
  logic signed [COEF_WIDTH-1:0]     coef0, coef1;
  logic signed [PROD_W-1:0]         prod0, prod1, prod2;
  mac_ctrl_t                        ctrl01, ctrl2;
  logic signed [SUM_W-1:0]          acc_sum, acc_rnd;
  logic signed [SAMPLE_WIDTH-1:0]   y_d;
  logic                             clip_d;
  logic signed [SUM_W-1:0]          s1_sum, s2_sum;

  // Handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign upd_go        = (state_q == S_UPDATE) & (~out_valid_q | m_axis_tready);
  assign last_dig      = (cnt_q == CNT_W'(NDIG - 1));

  // Register index decode: only the five coefficients count
  always_comb begin
    case (cfg_index_i)
      COEF_A0, COEF_A1, COEF_A2, COEF_B1, COEF_B2: cfg_hit = 1'b1;
      default:                                     cfg_hit = 1'b0;
    endcase
  end

  // Operands for the multiply units
  assign x_ext = EXT_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]));
  assign y_ext = EXT_W'(y_d);
  assign op01  = (state_q == S_ROUND) ? y_ext : x_ext;
  assign coef0 = (state_q == S_MUL_Y) ? coef_b1_q : coef_a0_q;
  assign coef1 = (state_q == S_MUL_Y) ? coef_b2_q : coef_a1_q;

  // Units 0 and 1 do a0/a1 then b1/b2; unit 2 does a2 and holds it
  always_comb begin
    ctrl01.load  = in_acc | (state_q == S_ROUND);
    ctrl01.step  = (state_q == S_MUL_X) | (state_q == S_MUL_Y);
    ctrl01.first = (cnt_q == '0);
    ctrl2.load   = in_acc;
    ctrl2.step   = (state_q == S_MUL_X);
    ctrl2.first  = (cnt_q == '0);
  end

  biq_digit_mac #(
    .OP_W   (EXT_W),
    .COEF_W (COEF_WIDTH)
  ) u_mac0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl01),
    .operand_i (op01),
    .coef_i    (coef0),
    .product_o (prod0)
  );

  biq_digit_mac #(
    .OP_W   (EXT_W),
    .COEF_W (COEF_WIDTH)
  ) u_mac1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl01),
    .operand_i (op01),
    .coef_i    (coef1),
    .product_o (prod1)
  );

  biq_digit_mac #(
    .OP_W   (EXT_W),
    .COEF_W (COEF_WIDTH)
  ) u_mac2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl2),
    .operand_i (x_ext),
    .coef_i    (coef_a2_q),
    .product_o (prod2)
  );

  // Output: x*a0 + s1, round half up, saturate to sample range
  always_comb begin
    acc_sum = SUM_W'($signed(prod0[DELAY_W-1:0])) + SUM_W'(s1_q) + RND_HALF;
    acc_rnd = acc_sum >>> COEF_FRAC;
    if (acc_rnd > SMAX) begin
      y_d    = SMAX[SAMPLE_WIDTH-1:0];
      clip_d = 1'b1;
    end else if (acc_rnd < SMIN) begin
      y_d    = SMIN[SAMPLE_WIDTH-1:0];
      clip_d = 1'b1;
    end else begin
      y_d    = acc_rnd[SAMPLE_WIDTH-1:0];
      clip_d = 1'b0;
    end
  end

  // New delays from the feedback products
  assign s1_sum = t1_q - SUM_W'($signed(prod0[DELAY_W-1:0]));
  assign s2_sum = SUM_W'($signed(prod2[DELAY_W-1:0]))
                - SUM_W'($signed(prod1[DELAY_W-1:0]));

  // Sequencer, coefficients, delays and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      coef_a0_q   <= A0_RESET;
      coef_a1_q   <= '0;
      coef_a2_q   <= '0;
      coef_b1_q   <= '0;
      coef_b2_q   <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      if (upd_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_acc && cfg_hit) begin
        s1_q <= '0;
        s2_q <= '0;
        case (cfg_index_i)
          COEF_A0: coef_a0_q <= cfg_data_i;
          COEF_A1: coef_a1_q <= cfg_data_i;
          COEF_A2: coef_a2_q <= cfg_data_i;
          COEF_B1: coef_b1_q <= cfg_data_i;
          COEF_B2: coef_b2_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_acc) begin
            state_q <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (last_dig) begin
            cnt_q   <= '0;
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          state_q <= S_MUL_Y;
        end
        S_MUL_Y: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (last_dig) begin
            cnt_q   <= '0;
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (upd_go) begin
            s1_q    <= sat_delay(s1_sum);
            s2_q    <= sat_delay(s2_sum);
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_ROUND) begin
      y_q    <= y_d;
      clip_q <= clip_d;
      t1_q   <= SUM_W'($signed(prod1[DELAY_W-1:0])) + SUM_W'(s2_q);
    end
    if (upd_go) begin
      out_sample_q <= y_q;
      out_clip_q   <= clip_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_sample_q);
  assign m_axis_tuser  = out_clip_q;

endmodule : biquad_iir_filter_unit

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the biquad filter unit: directed table, then random batches.
`timescale 1ns / 1ps

module testbench;
  import biq_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int CW = COEF_WIDTH_DEF;
  localparam int CF = COEF_FRAC_DEF;
  localparam int DELAY_W = SW + CW;
  // Extra idle time after the last expected word has come back
  localparam int SETTLE_CYCLES = 16;
  localparam int NUM_ROWS = 38;
  localparam int BATCHES_PER_PHASE = 12;

  // Register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] COEF_SPARE = CFG_IDX_W'(NUM_COEFS);
  localparam logic [CFG_IDX_W-1:0] COEF_TOP   = '1;

  typedef enum logic {ROW_SAMPLE, ROW_COEF} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CW-1:0]          value;
    logic                   fixed_want;
    logic [SW-1:0]          want_sample;
    logic                   want_clip;
  } stim_row_t;

  typedef struct packed {
    logic [SW-1:0] sample;
    logic          clip;
  } filt_word_t;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [SW-1:0] s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [SW-1:0] m_axis_tdata;
  logic          m_axis_tuser;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CW-1:0] cfg_data_i;

  // Filter state mirrored by the bench
  longint coef_q [NUM_COEFS];
  longint dly1_q;
  longint dly2_q;

  filt_word_t awaited_words [$];
  int mismatch_count = 0;
  int send_idle_pct = 25;
  int recv_stall_pct = 63;

  // Directed table: extremes, rounding halves, delay saturation, clears, ignored indexes
  stim_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_8000, 1'b1, 16'h8000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0001, 1'b1, 16'h0001, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_FFFF, 1'b1, 16'hFFFF, 1'b0},
    '{ROW_COEF,   COEF_A0, 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_7FFF, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_8000, 1'b1, 16'h8000, 1'b1},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0001, 1'b1, 16'h0008, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_A0, 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_7FFF, 1'b1, 16'h8000, 1'b1},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_8000, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0001, 1'b1, 16'hFFF8, 1'b0},
    '{ROW_COEF,   COEF_A0, 32'h0800_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0001, 1'b1, 16'h0001, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_FFFF, 1'b1, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0003, 1'b1, 16'h0002, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_FFFD, 1'b1, 16'hFFFF, 1'b0},
    '{ROW_COEF,   COEF_A1, 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_A2, 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_B1, 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_B2, 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_A0, 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_8000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_SPARE, 32'h1234_5678, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_TOP, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0001, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_B1, 32'h1000_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_0064, 1'b0, 16'h0000, 1'b0},
    '{ROW_COEF,   COEF_A0, 32'h0400_0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_4000, 1'b0, 16'h0000, 1'b0},
    '{ROW_SAMPLE, COEF_A0, 32'h0000_C000, 1'b0, 16'h0000, 1'b0}
  };

  biquad_iir_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Saturate to a signed range of w bits
  function automatic longint clamp_to(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // One filter step: expected output word, delays advanced
  function automatic filt_word_t next_filter_word(logic [SW-1:0] x_in);
    longint x;
    longint acc;
    longint y;
    longint y_sat;
    filt_word_t w;
    x = longint'($signed(x_in));
    acc = x * coef_q[COEF_A0] + dly1_q;
    // round half up, then floor
    y = (acc + (longint'(1) <<< (CF - 1))) >>> CF;
    y_sat = clamp_to(y, SW);
    w.sample = y_sat[SW-1:0];
    w.clip = (y_sat != y);
    // feedback uses the saturated sample
    dly1_q = clamp_to(x * coef_q[COEF_A1] + dly2_q - coef_q[COEF_B1] * y_sat, DELAY_W);
    dly2_q = clamp_to(x * coef_q[COEF_A2] - coef_q[COEF_B2] * y_sat, DELAY_W);
    return w;
  endfunction

  // Coefficient store; valid indexes also clear the delays
  function automatic void load_coef(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    if (idx < NUM_COEFS) begin
      coef_q[idx] = longint'($signed(val));
      dly1_q = 0;
      dly2_q = 0;
    end
  endfunction

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    load_coef(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one sample word; queue either the table value or the predicted one
  task automatic push_sample(input logic [SW-1:0] x, input logic use_table,
                             input filt_word_t table_word);
    filt_word_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= SW'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = next_filter_word(x);
    awaited_words.push_back(use_table ? table_word : predicted);
  endtask

  // Hold off the sender until every expected word is back
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Output checker and receiver back-pressure
  always @(posedge clk_i) begin : out_check
    filt_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got sample %h clip %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = awaited_words.pop_front();
        if (m_axis_tdata !== want.sample) begin
          $display("%0t: sample_out: expected %h, got %h", $time, want.sample, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.clip) begin
          $display("%0t: clipped: expected %b, got %b", $time, want.clip, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Stimulus
  initial begin : stimulus
    stim_row_t row;
    filt_word_t table_word;
    logic [CW-1:0] cval;
    logic [SW-1:0] xval;
    int lim;
    int n_items;
    int style;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= COEF_A0;
    cfg_data_i    <= '0;

    // bypass after reset
    coef_q[COEF_A0] = longint'(1) <<< CF;
    coef_q[COEF_A1] = 0;
    coef_q[COEF_A2] = 0;
    coef_q[COEF_B1] = 0;
    coef_q[COEF_B2] = 0;
    dly1_q = 0;
    dly2_q = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_COEF) begin
        settle_idle();
        write_coef(row.idx, row.value);
      end else begin
        table_word.sample = row.want_sample;
        table_word.clip   = row.want_clip;
        push_sample(row.value[SW-1:0], row.fixed_want, table_word);
      end
    end

    // Random batches over three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 25; recv_stall_pct = 63; end
        1: begin send_idle_pct = 63; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int b = 0; b < BATCHES_PER_PHASE; b++) begin
        settle_idle();
        style = $urandom_range(0, 3);
        for (int i = 0; i < NUM_COEFS; i++) begin
          if ($urandom_range(0, 9) < 7) begin
            case (style)
              // whole range
              0: cval = $urandom;
              // corner values
              1: begin
                case ($urandom_range(0, 4))
                  0: cval = 32'h7FFF_FFFF;
                  1: cval = 32'h8000_0000;
                  2: cval = 32'h0000_0000;
                  3: cval = 32'h1000_0000;
                  default: cval = 32'hF000_0000;
                endcase
              end
              // modest gains, wider b1
              2: begin
                lim = (i == COEF_B1) ? (1 << 29) : (1 << 27);
                cval = CW'(int'($urandom_range(0, 2 * lim)) - lim);
              end
              // near bypass with small taps
              default: begin
                lim = 1 << 20;
                cval = CW'(int'($urandom_range(0, 2 * lim)) - lim);
                if (i == COEF_A0) cval = cval + (CW'(1) << CF);
              end
            endcase
            write_coef(CFG_IDX_W'(i), cval);
          end
        end
        if ($urandom_range(0, 3) == 0)
          write_coef(CFG_IDX_W'($urandom_range(NUM_COEFS, (1 << CFG_IDX_W) - 1)), $urandom);

        n_items = $urandom_range(36, 60);
        for (int k = 0; k < n_items; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: xval = SW'($urandom);
            5, 6, 7: xval = SW'(int'($urandom_range(0, 1024)) - 512);
            default: begin
              case ($urandom_range(0, 4))
                0: xval = 16'h7FFF;
                1: xval = 16'h8000;
                2: xval = 16'h0000;
                3: xval = 16'h0001;
                default: xval = 16'hFFFF;
              endcase
            end
          endcase
          push_sample(xval, 1'b0, '0);
        end
      end
    end

    settle_idle();
    if (mismatch_count == 0 && awaited_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
